[sv/assert_macros.svh]
// assertion macros used by the checker file frr_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/frr_pkg.sv]
// shared types and constants of the fragmented frame reassembler
// no dependencies
package frr_pkg;

    localparam int unsigned LEN_W  = 16;
    localparam int unsigned CAP_W  = 24;
    localparam int unsigned TYPE_W = 8;
    localparam int unsigned SIZE_W = 25;
    localparam int unsigned CFG_W  = 24;
    localparam int unsigned IDX_W  = 2;

    localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 16'd1500;
    localparam logic [CAP_W-1:0]  FRAME_CAP_RST = 24'd1048576;
    localparam logic [TYPE_W-1:0] VIDEO_TYPE_RST = 8'hf1;
    localparam logic [LEN_W-1:0]  MIN_PACKET = 16'd10;
    localparam logic [LEN_W-1:0]  POS_TYPE   = 16'd6;
    localparam logic [LEN_W-1:0]  POS_FRAG   = 16'd9;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = {SIZE_W{1'b1}};
    localparam logic [7:0]        CODE_START = 8'h01;
    localparam logic [7:0]        CODE_END   = 8'h03;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_MAX_LEN    = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_CAP  = 2'd1;
    localparam logic [IDX_W-1:0] REG_VIDEO_TYPE = 2'd2;

    typedef enum logic [1:0] {
        KIND_MIDDLE = 2'd0,
        KIND_START  = 2'd1,
        KIND_END    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [LEN_W-1:0]  max_len;
        logic [CAP_W-1:0]  frame_cap;
        logic [TYPE_W-1:0] video_type;
    } cfg_t;

    typedef struct packed {
        logic              payload_valid;
        logic [7:0]        payload_byte;
        logic              frame_done;
        logic [SIZE_W-1:0] frame_length;
        logic              frame_dropped;
        logic              length_error;
    } res_t;

endpackage

[sv/fragmented_frame_reassembler.sv]
// Fragmented frame reassembler: one received byte per item, results from a result register.
// A result shows on out_valid the cycle after its byte is accepted.
// One byte per cycle while rx_ready is high; rx_ready drops only while a result waits with out_ready low.
// Reset (rst_n, async, active low) clears position, frame size and halt flag and
// restores the configuration registers to 1500, 1048576 and 0xf1.
module fragmented_frame_reassembler
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [frr_pkg::IDX_W-1:0]          cfg_index,
    input  logic [frr_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               rx_valid,
    output logic                               rx_ready,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               payload_valid,
    output logic [7:0]                         payload_byte,
    output logic                               frame_done,
    output logic [frr_pkg::SIZE_W-1:0]         frame_length,
    output logic                               frame_dropped,
    output logic                               length_error
);

    frr_pkg::cfg_t cfg;
    frr_pkg::res_t res;
    frr_pkg::res_t res_q;
    logic          res_any;
    logic          fire;

    // accept while the result register is free or being emptied
    assign rx_ready = !out_valid || out_ready;
    assign fire     = rx_valid && rx_ready;

    frr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frr_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (rx_byte),
        .cfg     (cfg),
        .res_any (res_any),
        .res     (res)
    );

    frr_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_any),
        .res_in    (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_q)
    );

    // result fields to ports
    assign payload_valid = res_q.payload_valid;
    assign payload_byte  = res_q.payload_byte;
    assign frame_done    = res_q.frame_done;
    assign frame_length  = res_q.frame_length;
    assign frame_dropped = res_q.frame_dropped;
    assign length_error  = res_q.length_error;

endmodule

[sv/frr_cfg_regs.sv]
// configuration registers of the reassembler
// depends on frr_pkg
module frr_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [frr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [frr_pkg::CFG_W-1:0]   cfg_data,
    output frr_pkg::cfg_t               cfg
);

    frr_pkg::cfg_t cfg_reg;
    frr_pkg::cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                frr_pkg::REG_MAX_LEN:    cfg_next.max_len = cfg_data[frr_pkg::LEN_W-1:0];
                frr_pkg::REG_FRAME_CAP:  cfg_next.frame_cap = cfg_data[frr_pkg::CAP_W-1:0];
                frr_pkg::REG_VIDEO_TYPE: cfg_next.video_type = cfg_data[frr_pkg::TYPE_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_len    <= frr_pkg::MAX_LEN_RST;
            cfg_reg.frame_cap  <= frr_pkg::FRAME_CAP_RST;
            cfg_reg.video_type <= frr_pkg::VIDEO_TYPE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/frr_parser.sv]
// packet parser: position tracking, fragment handling and frame size count
// depends on frr_pkg
module frr_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           rx_byte,
    input  frr_pkg::cfg_t        cfg,
    output logic                 res_any,
    output frr_pkg::res_t        res
);

    logic [frr_pkg::LEN_W-1:0]  pos_reg, pos_next;
    logic [frr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                       match_reg, match_next;
    frr_pkg::kind_t             kind_reg, kind_next;
    logic [frr_pkg::SIZE_W-1:0] size_reg, size_next;
    logic                       halted_reg, halted_next;

    logic [frr_pkg::LEN_W-1:0]  len_full;
    logic                       last;
    frr_pkg::kind_t             kind_code;

    assign len_full = {rx_byte, len_reg[7:0]};
    assign last     = (pos_reg == len_reg - 16'd1);

    // fragment code decode
    always_comb
    begin
        if (rx_byte == frr_pkg::CODE_START)
            kind_code = frr_pkg::KIND_START;
        else if (rx_byte == frr_pkg::CODE_END)
            kind_code = frr_pkg::KIND_END;
        else
            kind_code = frr_pkg::KIND_MIDDLE;
    end

    // next state and result for the current byte
    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        match_next  = match_reg;
        kind_next   = kind_reg;
        size_next   = size_reg;
        halted_next = halted_reg;
        res         = '0;
        if (!halted_reg)
        begin
            if (pos_reg == 16'd0)
            begin
                len_next = {8'h00, rx_byte};
                pos_next = 16'd1;
            end
            else if (pos_reg == 16'd1)
            begin
                len_next   = len_full;
                match_next = 1'b0;
                kind_next  = frr_pkg::KIND_MIDDLE;
                if (len_full > cfg.max_len)
                begin
                    halted_next      = 1'b1;
                    pos_next         = 16'd0;
                    res.length_error = 1'b1;
                end
                else
                begin
                    pos_next = (len_full <= 16'd2) ? 16'd0 : 16'd2;
                end
            end
            else
            begin
                if (len_reg >= frr_pkg::MIN_PACKET)
                begin
                    priority if (pos_reg == frr_pkg::POS_TYPE)
                    begin
                        match_next = (rx_byte == cfg.video_type);
                    end
                    else if (pos_reg == frr_pkg::POS_FRAG && match_reg)
                    begin
                        kind_next = kind_code;
                        if (kind_code == frr_pkg::KIND_START && size_reg != '0)
                        begin
                            res.frame_dropped = 1'b1;
                            size_next         = '0;
                        end
                        else if (kind_code == frr_pkg::KIND_MIDDLE
                                 && size_reg > {1'b0, cfg.frame_cap})
                        begin
                            res.frame_dropped = 1'b1;
                            size_next         = '0;
                        end
                    end
                    else if (pos_reg >= frr_pkg::MIN_PACKET && match_reg)
                    begin
                        res.payload_valid = 1'b1;
                        res.payload_byte  = rx_byte;
                        if (size_reg != frr_pkg::SIZE_MAX)
                            size_next = size_reg + 25'd1;
                    end
                    else
                    begin
                        // other header bytes and foreign packets leave the kind alone
                        kind_next = kind_reg;
                    end
                    // end fragment completes on the packet's last byte
                    if (pos_reg >= frr_pkg::POS_FRAG && match_reg && last
                        && kind_next == frr_pkg::KIND_END)
                    begin
                        res.frame_done   = 1'b1;
                        res.frame_length = size_next;
                        size_next        = '0;
                    end
                end
                pos_next = last ? 16'd0 : pos_reg + 16'd1;
            end
        end
    end

    assign res_any = res.payload_valid | res.frame_done | res.frame_dropped
                   | res.length_error;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            match_reg  <= 1'b0;
            kind_reg   <= frr_pkg::KIND_MIDDLE;
            size_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            match_reg  <= match_next;
            kind_reg   <= kind_next;
            size_reg   <= size_next;
            halted_reg <= halted_next;
        end
    end

endmodule

[sv/frr_out_reg.sv]
// result register between the parser and the output channel
// depends on frr_pkg
module frr_out_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  frr_pkg::res_t  res_in,
    input  logic           out_ready,
    output logic           out_valid,
    output frr_pkg::res_t  res_out
);

    logic          valid_reg, valid_next;
    frr_pkg::res_t data_reg;

    // occupancy: a load refills in the same cycle the old item leaves
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

[sv/frr_checker.sv]
// port-level checks of the reassembler, bound to the top level
// depends on frr_pkg and assert_macros.svh
`include "assert_macros.svh"

module frr_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rx_valid,
    input  logic                       rx_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       payload_valid,
    input  logic [7:0]                 payload_byte,
    input  logic                       frame_done,
    input  logic [frr_pkg::SIZE_W-1:0] frame_length,
    input  logic                       frame_dropped,
    input  logic                       length_error
);

    // a stalled item stays valid and holds its payload byte, frame length and done flag
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(payload_byte) && $stable(frame_length) && $stable(frame_done))

    // every item carries a flag, and unflagged fields read zero
    `ASSERT_IMPLY(a_item_flags, clk, rst_n, out_valid,
        (payload_valid || frame_done || frame_dropped || length_error)
        && (frame_done || frame_length == '0) && (payload_valid || payload_byte == 8'd0))

    // a length error stands alone, and a drop never coincides with completion
    `ASSERT_IMPLY(a_flag_excl, clk, rst_n, out_valid,
        !(length_error && (payload_valid || frame_done || frame_dropped))
        && !(frame_dropped && frame_done))

    // nothing follows a delivered length error
    `ASSERT_NEXT(a_halt_quiet, clk, rst_n, out_valid && out_ready && length_error,
        !out_valid)

endmodule

bind fragmented_frame_reassembler frr_checker u_frr_checker (.*);
